### sv/mcbo_pkg.sv
`default_nettype none
package mcbo_pkg;

  // Field widths of one request and one result.
  localparam int BppW    = 4;
  localparam int DimW    = 15;
  localparam int DepthW  = 12;
  localparam int MipW    = 4;
  localparam int XyW     = 14;
  localparam int ZW      = 11;
  localparam int ResultW = 43;
  localparam int StrideW = 18;
  localparam int LevelW  = 5;

  // What one pass through the multiplier pipeline computes.
  localparam logic [1:0] KIND_LEVEL = 2'd0;  // whole size of one mip level
  localparam logic [1:0] KIND_SLICE = 2'd1;  // z times slice size
  localparam logic [1:0] KIND_ROW   = 2'd2;  // y times row stride
  localparam logic [1:0] KIND_TEXEL = 2'd3;  // x times pixel size

  typedef struct packed {
    logic              capture;
    logic              issue;
    logic [1:0]        kind;
    logic [LevelW-1:0] level;
    logic              load_out;
  } mcbo_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_busy;
  } mcbo_sts_t;

  // Dimension of a mip level: the base shifted down, never below one.
  function automatic logic [DimW-1:0] mip_dim(input logic [DimW-1:0] base,
                                              input logic [LevelW-1:0] level);
    logic [DimW-1:0] d;
    d = base >> level;
    return (d == '0) ? DimW'(1) : d;
  endfunction

endpackage
`default_nettype wire

### sv/mcbo_if.sv
`default_nettype none
interface mcbo_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [3:0]  bytes_per_pixel;
  logic [14:0] base_width;
  logic [14:0] base_height;
  logic [11:0] base_depth;
  logic [3:0]  first_mip;
  logic [3:0]  mip_count;
  logic [13:0] texel_x;
  logic [13:0] texel_y;
  logic [10:0] texel_z;

  modport source (
    output valid, command, bytes_per_pixel, base_width, base_height, base_depth,
           first_mip, mip_count, texel_x, texel_y, texel_z,
    input  ready
  );
  modport sink (
    input  valid, command, bytes_per_pixel, base_width, base_height, base_depth,
           first_mip, mip_count, texel_x, texel_y, texel_z,
    output ready
  );
endinterface

interface mcbo_rsp_if;
  logic        valid;
  logic        ready;
  logic [42:0] byte_result;
  logic [17:0] row_stride;

  modport source (output valid, byte_result, row_stride, input ready);
  modport sink (input valid, byte_result, row_stride, output ready);
endinterface
`default_nettype wire

### sv/mcbo_ctrl.sv
`default_nettype none
module mcbo_ctrl import mcbo_pkg::*; #(
  parameter int MAX_LEVELS = 15
) (
  input  logic       clk,
  input  logic       rst,
  mcbo_req_if.sink   req,
  input  mcbo_sts_t  sts,
  output mcbo_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LEVELS = 2'd1;
  localparam logic [1:0] ST_TERMS  = 2'd2;
  localparam logic [1:0] ST_DRAIN  = 2'd3;

  localparam logic [LevelW-1:0] LvlLimit = LevelW'(MAX_LEVELS);
  localparam logic [LevelW-1:0] LastLvl  = LevelW'(MAX_LEVELS - 1);

  logic [1:0]        state, state_next;
  logic [LevelW-1:0] lvl, lvl_next;
  logic [MipW-1:0]   remaining, remaining_next;
  logic [1:0]        term, term_next;
  logic              is_offset, is_offset_next;

  logic              accept;
  logic [MipW-1:0]   count_sat;
  logic [MipW-1:0]   first_sat;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  assign count_sat = ({1'b0, req.mip_count} > LvlLimit) ? LvlLimit[MipW-1:0] : req.mip_count;
  assign first_sat = ({1'b0, req.first_mip} > LastLvl) ? LastLvl[MipW-1:0] : req.first_mip;

  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    remaining_next = remaining;
    term_next      = term;
    is_offset_next = is_offset;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          is_offset_next = req.command;
          // Offsets sum every level below the addressed one, starting at zero.
          lvl_next       = req.command ? '0 : {1'b0, req.first_mip};
          remaining_next = req.command ? first_sat : count_sat;
          state_next     = ST_LEVELS;
        end
      end
      ST_LEVELS: begin
        if (remaining != '0) begin
          lvl_next       = lvl + LevelW'(1);
          remaining_next = remaining - MipW'(1);
        end else if (is_offset) begin
          term_next  = KIND_SLICE;
          state_next = ST_TERMS;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_TERMS: begin
        term_next = term + 2'd1;
        if (term == KIND_TEXEL) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.pipe_empty && !sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    lvl       <= lvl_next;
    remaining <= remaining_next;
    term      <= term_next;
    is_offset <= is_offset_next;
  end

  // During the offset terms lvl has come to rest on the addressed level.
  always_comb begin
    cmd.capture  = accept;
    cmd.issue    = ((state == ST_LEVELS) && (remaining != '0)) || (state == ST_TERMS);
    cmd.kind     = (state == ST_TERMS) ? term : KIND_LEVEL;
    cmd.level    = lvl;
    cmd.load_out = (state == ST_DRAIN) && sts.pipe_empty && !sts.out_busy;
  end

endmodule
`default_nettype wire

### sv/mcbo_datapath.sv
`default_nettype none
module mcbo_datapath import mcbo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              command,
  input  logic [BppW-1:0]   bytes_per_pixel,
  input  logic [DimW-1:0]   base_width,
  input  logic [DimW-1:0]   base_height,
  input  logic [DepthW-1:0] base_depth,
  input  logic [XyW-1:0]    texel_x,
  input  logic [XyW-1:0]    texel_y,
  input  logic [ZW-1:0]     texel_z,
  mcbo_rsp_if.source        rsp,
  input  mcbo_cmd_t         cmd,
  output mcbo_sts_t         sts
);

  localparam int P1W = 2 * DimW;

  logic              is_offset;
  logic [BppW-1:0]   bpp;
  logic [DimW-1:0]   w, h;
  logic [DepthW-1:0] d;
  logic [XyW-1:0]    x, y;
  logic [ZW-1:0]     z;

  logic [DimW-1:0]   mw, mh, md;
  logic [DimW-1:0]   op_a, op_b;
  logic [XyW-1:0]    op_c;

  logic              s1_valid, s2_valid, s3_valid;
  logic [P1W-1:0]    s1_p;
  logic [XyW-1:0]    s1_c;
  logic [ResultW-1:0] s2_p, s3_p;
  logic [P1W+XyW-1:0] p2_full;
  logic [ResultW+BppW-1:0] p3_full;
  logic [ResultW-1:0] acc;
  logic [DimW+BppW-1:0] stride_full;

  logic              out_valid;
  logic [ResultW-1:0] out_result;
  logic [StrideW-1:0] out_stride;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_offset <= command;
      bpp       <= bytes_per_pixel;
      w         <= base_width;
      h         <= base_height;
      d         <= base_depth;
      x         <= texel_x;
      y         <= texel_y;
      z         <= texel_z;
    end
  end

  assign mw = mip_dim(w, cmd.level);
  assign mh = mip_dim(h, cmd.level);
  assign md = mip_dim({{(DimW-DepthW){1'b0}}, d}, cmd.level);

  // Every term has the form a * b * c * bytes_per_pixel.
  always_comb begin
    case (cmd.kind)
      KIND_LEVEL: begin
        op_a = mw;
        op_b = mh;
        op_c = md[XyW-1:0];
      end
      KIND_SLICE: begin
        op_a = mw;
        op_b = mh;
        op_c = {{(XyW-ZW){1'b0}}, z};
      end
      KIND_ROW: begin
        op_a = mw;
        op_b = DimW'(1);
        op_c = y;
      end
      default: begin
        op_a = DimW'(1);
        op_b = DimW'(1);
        op_c = x;
      end
    endcase
  end

  assign p2_full     = s1_p * s1_c;
  assign p3_full     = s2_p * bpp;
  assign stride_full = mw * bpp;

  always_ff @(posedge clk) begin
    s1_p <= P1W'(op_a) * P1W'(op_b);
    s1_c <= op_c;
    s2_p <= p2_full[ResultW-1:0];
    s3_p <= p3_full[ResultW-1:0];
    if (cmd.capture) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= acc + s3_p;
    end
    if (cmd.load_out) begin
      out_result <= acc;
      out_stride <= is_offset ? stride_full[StrideW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.pipe_empty = !s1_valid && !s2_valid && !s3_valid;
  assign sts.out_busy   = out_valid && !rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.byte_result = out_result;
  assign rsp.row_stride  = out_stride;

endmodule
`default_nettype wire

### sv/mip_chain_byte_offset_top.sv
// Command 1 saturates first_mip to MAX_LEVELS - 1.
// Throughput: one request at a time; one level enters the three-stage multiplier
// pipeline per cycle, and the next request beat comes at the earliest when the result
// is first presented, which may be before the result beat is taken.
// Reset clears the controller state and all valid flags; no request is pending after it.
`default_nettype none
module mip_chain_byte_offset_top import mcbo_pkg::*; #(
  parameter int MAX_LEVELS = 15
) (
  input  logic       clk,
  input  logic       rst,
  mcbo_req_if.sink   req,
  mcbo_rsp_if.source rsp
);

  mcbo_cmd_t ctl_cmd;
  mcbo_sts_t dp_sts;

  mcbo_ctrl #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .req(req),
    .sts(dp_sts),
    .cmd(ctl_cmd)
  );

  mcbo_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .command(req.command),
    .bytes_per_pixel(req.bytes_per_pixel),
    .base_width(req.base_width),
    .base_height(req.base_height),
    .base_depth(req.base_depth),
    .texel_x(req.texel_x),
    .texel_y(req.texel_y),
    .texel_z(req.texel_z),
    .rsp(rsp),
    .cmd(ctl_cmd),
    .sts(dp_sts)
  );

  // A result is loaded only once every term has reached the accumulator.
  a_load_after_drain: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.load_out |-> dp_sts.pipe_empty && !dp_sts.out_busy)
    else $error("result loaded with terms still in flight");

  // No new request is taken while terms are still being issued.
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.issue |-> !req.ready)
    else $error("request accepted while issuing terms");

  // In the cycle after a capture the block is busy: it takes no request and loads no result.
  a_capture_then_busy: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.capture |=> !req.ready && !ctl_cmd.load_out)
    else $error("request beat not followed by processing");

endmodule
`default_nettype wire

### sim/mip_chain_byte_offset_top_tb.sv
`timescale 1ns / 100ps
module mip_chain_byte_offset_top_tb import mcbo_pkg::*; ();

  localparam int          MAX_LEVELS  = 15;
  localparam int          HOLD_CYCLES = 400;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 40;
  localparam logic        CMD_RANGE_SIZE   = 1'b0;
  localparam logic        CMD_TEXEL_OFFSET = 1'b1;

  typedef struct packed {
    logic              command;
    logic [BppW-1:0]   bytes_per_pixel;
    logic [DimW-1:0]   base_width;
    logic [DimW-1:0]   base_height;
    logic [DepthW-1:0] base_depth;
    logic [MipW-1:0]   first_mip;
    logic [MipW-1:0]   mip_count;
    logic [XyW-1:0]    texel_x;
    logic [XyW-1:0]    texel_y;
    logic [ZW-1:0]     texel_z;
  } request_t;

  typedef struct packed {
    logic [ResultW-1:0] byte_result;
    logic [StrideW-1:0] row_stride;
  } layout_t;

  logic clk;
  logic rst;

  mcbo_req_if req_if ();
  mcbo_rsp_if rsp_if ();

  mip_chain_byte_offset_top #(
    .MAX_LEVELS(MAX_LEVELS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  layout_t pending_layouts[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      steady_flow = 1'b0;
  int      hold_seq    = 0;
  int      hold_seen   = 0;
  int      hold_left   = 0;
  int      stall_left  = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] mip_extent(input logic [63:0] base, input int unsigned lvl);
    logic [63:0] d;
    d = (lvl < 32) ? (base >> lvl) : 64'd0;
    return (d == 64'd0) ? 64'd1 : d;
  endfunction

  function automatic logic [63:0] level_bytes(input request_t r, input int unsigned lvl);
    return mip_extent(r.base_width, lvl) * mip_extent(r.base_height, lvl) *
           mip_extent(r.base_depth, lvl) * 64'(r.bytes_per_pixel);
  endfunction

  function automatic layout_t mip_layout(input request_t r);
    logic [63:0] total;
    logic [63:0] stride;
    logic [63:0] bpp;
    int unsigned n;
    int unsigned lvl;
    layout_t     res;
    total = 64'd0;
    stride = 64'd0;
    bpp = 64'(r.bytes_per_pixel);
    if (r.command == CMD_RANGE_SIZE) begin
      n = (r.mip_count > MAX_LEVELS) ? MAX_LEVELS : r.mip_count;
      for (int unsigned i = 0; i < n; i++) total += level_bytes(r, r.first_mip + i);
    end else begin
      lvl = (r.first_mip > MAX_LEVELS - 1) ? MAX_LEVELS - 1 : r.first_mip;
      for (int unsigned i = 0; i < lvl; i++) total += level_bytes(r, i);
      stride = mip_extent(r.base_width, lvl) * bpp;
      // The offset uses the full stride even when the reported field wraps.
      total += stride * mip_extent(r.base_height, lvl) * 64'(r.texel_z) +
               stride * 64'(r.texel_y) + bpp * 64'(r.texel_x);
    end
    res.byte_result = total[ResultW-1:0];
    res.row_stride  = stride[StrideW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic request_t make_request(input logic c, input int unsigned bpp,
                                            input int unsigned w, input int unsigned h,
                                            input int unsigned d, input int unsigned first,
                                            input int unsigned count, input int unsigned x,
                                            input int unsigned y, input int unsigned z);
    request_t r;
    r.command         = c;
    r.bytes_per_pixel = BppW'(bpp);
    r.base_width      = DimW'(w);
    r.base_height     = DimW'(h);
    r.base_depth      = DepthW'(d);
    r.first_mip       = MipW'(first);
    r.mip_count       = MipW'(count);
    r.texel_x         = XyW'(x);
    r.texel_y         = XyW'(y);
    r.texel_z         = ZW'(z);
    return r;
  endfunction

  function automatic request_t rand_raw();
    request_t r;
    r.command         = 1'($urandom);
    r.bytes_per_pixel = BppW'($urandom);
    r.base_width      = DimW'($urandom);
    r.base_height     = DimW'($urandom);
    r.base_depth      = DepthW'($urandom);
    r.first_mip       = MipW'($urandom);
    r.mip_count       = MipW'($urandom);
    r.texel_x         = XyW'($urandom);
    r.texel_y         = XyW'($urandom);
    r.texel_z         = ZW'($urandom);
    return r;
  endfunction

  function automatic int unsigned rand_extent(input int unsigned legal_max,
                                              input int unsigned width);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom_range(1, 64);
    if (pick < 7) return $urandom_range(1, legal_max);
    if (pick < 9) return 1 << $urandom_range(0, $clog2(legal_max));
    return $urandom_range(0, (1 << width) - 1);
  endfunction

  function automatic int unsigned rand_coord(input logic [63:0] extent,
                                             input int unsigned width);
    // Half the coordinates land inside the level, the rest anywhere in the field.
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, int'(extent) - 1);
    return $urandom_range(0, (1 << width) - 1);
  endfunction

  function automatic request_t rand_request();
    request_t    r;
    int unsigned lvl;
    r.command         = ($urandom_range(0, 1) == 0) ? CMD_RANGE_SIZE : CMD_TEXEL_OFFSET;
    r.bytes_per_pixel = BppW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, 8));
    r.base_width      = DimW'(rand_extent(16384, DimW));
    r.base_height     = DimW'(rand_extent(16384, DimW));
    r.base_depth      = DepthW'(rand_extent(2048, DepthW));
    r.first_mip       = MipW'($urandom_range(0, 15));
    r.mip_count       = MipW'($urandom_range(0, 15));
    lvl = (r.first_mip > MAX_LEVELS - 1) ? MAX_LEVELS - 1 : r.first_mip;
    r.texel_x = XyW'(rand_coord(mip_extent(r.base_width, lvl), XyW));
    r.texel_y = XyW'(rand_coord(mip_extent(r.base_height, lvl), XyW));
    r.texel_z = ZW'(rand_coord(mip_extent(r.base_depth, lvl), ZW));
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic apply_fields(input request_t r);
    req_if.command         <= r.command;
    req_if.bytes_per_pixel <= r.bytes_per_pixel;
    req_if.base_width      <= r.base_width;
    req_if.base_height     <= r.base_height;
    req_if.base_depth      <= r.base_depth;
    req_if.first_mip       <= r.first_mip;
    req_if.mip_count       <= r.mip_count;
    req_if.texel_x         <= r.texel_x;
    req_if.texel_y         <= r.texel_y;
    req_if.texel_z         <= r.texel_z;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_request(input request_t r);
    int unsigned gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      apply_fields(rand_raw());
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    apply_fields(r);
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and checking
  // ---------------------------------------------------------------------------

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (steady_flow) begin
        rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
        rsp_if.ready <= (stall_left == 0);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_beats
    layout_t  want;
    request_t seen;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_layouts.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding, byte_result %0d",
                                    rsp_if.byte_result));
        end else begin
          want = pending_layouts.pop_front();
          if (rsp_if.byte_result !== want.byte_result)
            report_mismatch($sformatf("byte_result got %0d expected %0d",
                                      rsp_if.byte_result, want.byte_result));
          if (rsp_if.row_stride !== want.row_stride)
            report_mismatch($sformatf("row_stride got %0d expected %0d",
                                      rsp_if.row_stride, want.row_stride));
        end
      end
      if (req_if.valid && req_if.ready) begin
        seen.command         = req_if.command;
        seen.bytes_per_pixel = req_if.bytes_per_pixel;
        seen.base_width      = req_if.base_width;
        seen.base_height     = req_if.base_height;
        seen.base_depth      = req_if.base_depth;
        seen.first_mip       = req_if.first_mip;
        seen.mip_count       = req_if.mip_count;
        seen.texel_x         = req_if.texel_x;
        seen.texel_y         = req_if.texel_y;
        seen.texel_z         = req_if.texel_z;
        pending_layouts.push_back(mip_layout(seen));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_corners();
    send_request(make_request(CMD_RANGE_SIZE, 4, 256, 256, 1, 0, 9, 0, 0, 0));
    send_request(make_request(CMD_RANGE_SIZE, 8, 16384, 16384, 2048, 0, 15, 0, 0, 0));
    // All-ones sizes make the sum wrap.
    send_request(make_request(CMD_RANGE_SIZE, 15, 32767, 32767, 4095, 0, 15, 0, 0, 0));
    send_request(make_request(CMD_RANGE_SIZE, 4, 64, 64, 1, 3, 0, 0, 0, 0));
    send_request(make_request(CMD_RANGE_SIZE, 0, 100, 100, 10, 0, 5, 0, 0, 0));
    send_request(make_request(CMD_RANGE_SIZE, 2, 0, 0, 0, 0, 4, 0, 0, 0));
    // Levels well past the end of the chain still count as one texel each.
    send_request(make_request(CMD_RANGE_SIZE, 1, 1024, 512, 4, 15, 15, 0, 0, 0));
    send_request(make_request(CMD_RANGE_SIZE, 3, 37, 5, 1, 10, 15, 1, 2, 3));
    send_request(make_request(CMD_RANGE_SIZE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_TEXEL_OFFSET, 4, 256, 256, 1, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_TEXEL_OFFSET, 4, 256, 256, 1, 3, 0, 31, 31, 0));
    send_request(make_request(CMD_TEXEL_OFFSET, 8, 16384, 16384, 2048, 14, 0,
                              16383, 16383, 2047));
    send_request(make_request(CMD_TEXEL_OFFSET, 2, 512, 512, 8, 15, 3, 1, 1, 0));
    // The stride no longer fits its field here.
    send_request(make_request(CMD_TEXEL_OFFSET, 15, 32767, 32767, 4095, 0, 0,
                              16383, 16383, 2047));
    send_request(make_request(CMD_TEXEL_OFFSET, 8, 16384, 64, 64, 0, 0, 16383, 63, 63));
    send_request(make_request(CMD_TEXEL_OFFSET, 0, 100, 100, 4, 2, 0, 5, 5, 1));
    send_request(make_request(CMD_TEXEL_OFFSET, 1, 0, 0, 0, 5, 0, 3, 2, 1));
    send_request(make_request(CMD_TEXEL_OFFSET, 4, 1000, 700, 30, 4, 7, 1000, 1000, 100));
    send_request(make_request(CMD_TEXEL_OFFSET, 15, 32767, 32767, 4095, 15, 15,
                              16383, 16383, 2047));
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(rand_raw());
      else send_request(rand_request());
    end
  endtask

  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    for (int i = 0; i < count; i++) send_request(rand_request());
    steady_flow = 1'b0;
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the block backs up and stalls its request side.
  task automatic test_result_backpressure(input int count);
    steady_flow = 1'b1;
    hold_seq++;
    for (int i = 0; i < count; i++) send_request(rand_request());
    hold_seq++;
    for (int i = 0; i < count; i++) send_request(rand_request());
    steady_flow = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    apply_fields('0);
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    test_random_mix(600);
    test_back_to_back(80);
    test_result_backpressure(25);
    test_random_mix(30);

    req_if.valid <= 1'b0;
    while (pending_layouts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mcbo_pkg.sv
sv/mcbo_if.sv
sv/mcbo_ctrl.sv
sv/mcbo_datapath.sv
sv/mip_chain_byte_offset_top.sv
sim/mip_chain_byte_offset_top_tb.sv
